// ===== design/crast_pkg.sv =====
// Shared constants, types and the symmetry table of the circle rasteriser.
package crast_pkg;

  // Default geometry of the block.
  localparam int COORD_BITS_DEF  = 12;
  localparam int RADIUS_BITS_DEF = 10;

  // Number of entries in the command queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  // Input kind codes carried in tuser.
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_STEP  = 1'b1;

  // Index of the final point of an eight-way group.
  localparam logic [2:0] LAST_POINT = 3'd7;

  // Control part of one command handed from front to back.
  typedef struct packed {
    logic idle;  // answer to a step with no walk in progress
    logic done;  // the walk finished with this command
  } ctrl_t;

  // How one symmetric point is formed from (x, y).
  typedef struct packed {
    logic swap;   // take (y, x) instead of (x, y)
    logic neg_a;  // negate the first coordinate
    logic neg_b;  // negate the second coordinate
  } sym_t;

  // Point order: (x,y) (-x,-y) (y,x) (-y,-x) (-y,x) (y,-x) (-x,y) (x,-y).
  function automatic sym_t sym_of(input logic [2:0] k);
    sym_t s;
    unique case (k)
      3'd0: s = '{swap: 1'b0, neg_a: 1'b0, neg_b: 1'b0};
      3'd1: s = '{swap: 1'b0, neg_a: 1'b1, neg_b: 1'b1};
      3'd2: s = '{swap: 1'b1, neg_a: 1'b0, neg_b: 1'b0};
      3'd3: s = '{swap: 1'b1, neg_a: 1'b1, neg_b: 1'b1};
      3'd4: s = '{swap: 1'b1, neg_a: 1'b1, neg_b: 1'b0};
      3'd5: s = '{swap: 1'b1, neg_a: 1'b0, neg_b: 1'b1};
      3'd6: s = '{swap: 1'b0, neg_a: 1'b1, neg_b: 1'b0};
      default: s = '{swap: 1'b0, neg_a: 1'b0, neg_b: 1'b1};
    endcase
    return s;
  endfunction

endpackage

// ===== design/crast_front.sv =====
// Front end: accepts input transfers, runs the octant walk and issues commands.
module crast_front import crast_pkg::*; #(
  parameter int COORD_BITS  = COORD_BITS_DEF,
  parameter int RADIUS_BITS = RADIUS_BITS_DEF,
  parameter int SW          = RADIUS_BITS + 2
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_action,
  input  logic signed [COORD_BITS-1:0]  in_cx,
  input  logic signed [COORD_BITS-1:0]  in_cy,
  input  logic        [RADIUS_BITS-1:0] in_radius,
  output logic                          cmd_push,
  input  logic                          cmd_ready,
  output logic signed [SW-1:0]          cmd_x,
  output logic signed [SW-1:0]          cmd_y,
  output logic signed [COORD_BITS-1:0]  cmd_cx,
  output logic signed [COORD_BITS-1:0]  cmd_cy,
  output ctrl_t                         cmd_ctrl
);

  localparam int DEC_BITS = RADIUS_BITS + 4;

  logic                          active;
  logic        [RADIUS_BITS-1:0] walk_x;
  logic        [RADIUS_BITS-1:0] walk_y;
  logic signed [DEC_BITS-1:0]    decision;
  logic signed [COORD_BITS-1:0]  centre_x;
  logic signed [COORD_BITS-1:0]  centre_y;

  logic                          accept;
  logic                          dec_le0;
  logic signed [SW-1:0]          x_next;
  logic signed [SW-1:0]          y_next;
  logic signed [DEC_BITS-1:0]    decision_next;
  logic signed [DEC_BITS-1:0]    x4;
  logic signed [DEC_BITS-1:0]    y4;
  logic signed [DEC_BITS-1:0]    start_dec;
  logic                          step_done;

  assign in_ready = cmd_ready;
  assign accept   = in_valid && cmd_ready;

  // One column of the midpoint walk.
  always_comb begin
    // Negative or zero decision: the sign bit or an all-zero value.
    dec_le0       = decision[DEC_BITS-1] || (decision == '0);
    x4            = {2'b00, walk_x, 2'b00};
    y4            = {2'b00, walk_y, 2'b00};
    x_next        = {2'b00, walk_x} + SW'(1);
    if (dec_le0) begin
      y_next        = {2'b00, walk_y};
      decision_next = decision + x4 + DEC_BITS'(6);
    end else begin
      y_next        = {2'b00, walk_y} - SW'(1);
      decision_next = decision + x4 - y4 + DEC_BITS'(10);
    end
    step_done = (x_next > y_next);
    start_dec = DEC_BITS'(3) - {3'b000, in_radius, 1'b0};
  end

  // Command issued for the accepted transfer.
  always_comb begin
    cmd_push      = accept;
    cmd_cx        = centre_x;
    cmd_cy        = centre_y;
    cmd_x         = x_next;
    cmd_y         = y_next;
    cmd_ctrl.idle = 1'b0;
    cmd_ctrl.done = step_done;
    if (in_action == ACT_START) begin
      cmd_cx        = in_cx;
      cmd_cy        = in_cy;
      cmd_x         = '0;
      cmd_y         = {2'b00, in_radius};
      cmd_ctrl.done = 1'b0;
    end else if (!active) begin
      cmd_x         = '0;
      cmd_y         = '0;
      cmd_ctrl.idle = 1'b1;
      cmd_ctrl.done = 1'b1;
    end
  end

  // Walk state.
  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      walk_x   <= '0;
      walk_y   <= '0;
      decision <= '0;
      centre_x <= '0;
      centre_y <= '0;
    end else if (accept) begin
      if (in_action == ACT_START) begin
        active   <= 1'b1;
        walk_x   <= '0;
        walk_y   <= in_radius;
        decision <= start_dec;
        centre_x <= in_cx;
        centre_y <= in_cy;
      end else if (active) begin
        active   <= !step_done;
        walk_x   <= x_next[RADIUS_BITS-1:0];
        walk_y   <= y_next[RADIUS_BITS-1:0];
        decision <= decision_next;
      end else begin
        active <= 1'b0;
      end
    end
  end

endmodule

// ===== design/crast_fifo.sv =====
// Short command queue that decouples the front end from the pixel emitter.
module crast_fifo import crast_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             ready,
  input  logic [WIDTH-1:0] wdata,
  output logic             valid,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign ready   = (count != CNT_W'(QUEUE_DEPTH));
  assign valid   = (count != '0);
  assign do_push = push && ready;
  assign do_pop  = pop && valid;
  assign rdata   = entries[rd_ptr];

  // Storage is written in place; no reset needed for payload.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue fill level exceeds its depth");

  a_push_full: assert property (@(posedge clk) disable iff (rst)
    (count == CNT_W'(QUEUE_DEPTH)) && !do_pop |=> (count == CNT_W'(QUEUE_DEPTH)))
    else $error("full queue lost an entry without a pop");

  a_empty_after_pop: assert property (@(posedge clk) disable iff (rst)
    (count == CNT_W'(1)) && do_pop && !do_push |=> !valid)
    else $error("queue still valid after its last entry was taken");

endmodule

// ===== design/crast_back.sv =====
// Back end: expands each command into its eight symmetric pixel transfers, or an idle answer into one transfer.
module crast_back import crast_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int SW         = RADIUS_BITS_DEF + 2,
  parameter int PIX_BITS   = COORD_BITS + 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cmd_valid,
  output logic                         cmd_pop,
  input  logic signed [SW-1:0]         cmd_x,
  input  logic signed [SW-1:0]         cmd_y,
  input  logic signed [COORD_BITS-1:0] cmd_cx,
  input  logic signed [COORD_BITS-1:0] cmd_cy,
  input  ctrl_t                        cmd_ctrl,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic        [PIX_BITS-1:0]   out_px,
  output logic        [PIX_BITS-1:0]   out_py,
  output logic                         out_pixel_valid,
  output logic                         out_last,
  output logic                         out_done
);

  localparam int WIDE = (PIX_BITS > SW) ? PIX_BITS : SW;

  // Command being expanded.
  logic                         busy;
  logic [2:0]                   idx;
  logic signed [SW-1:0]         cur_x;
  logic signed [SW-1:0]         cur_y;
  logic signed [COORD_BITS-1:0] cur_cx;
  logic signed [COORD_BITS-1:0] cur_cy;
  ctrl_t                        cur_ctrl;

  logic                         out_adv;
  logic                         emit;
  logic                         cmd_end;
  logic                         load;
  sym_t                         sym;
  logic signed [WIDE-1:0]       a_w;
  logic signed [WIDE-1:0]       b_w;
  logic signed [WIDE-1:0]       px_w;
  logic signed [WIDE-1:0]       py_w;

  assign out_adv = !out_valid || out_ready;
  assign emit    = busy && out_adv;
  assign cmd_end = cur_ctrl.idle || (idx == LAST_POINT);
  assign load    = cmd_valid && (!busy || (emit && cmd_end));
  assign cmd_pop = load;

  // Form the current symmetric point and offset it by the centre.
  always_comb begin
    sym  = sym_of(idx);
    a_w  = sym.swap ? WIDE'(cur_y) : WIDE'(cur_x);
    b_w  = sym.swap ? WIDE'(cur_x) : WIDE'(cur_y);
    if (sym.neg_a) begin
      a_w = -a_w;
    end
    if (sym.neg_b) begin
      b_w = -b_w;
    end
    px_w = a_w + WIDE'(cur_cx);
    py_w = b_w + WIDE'(cur_cy);
  end

  // Command register and point counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (emit) begin
      if (cmd_end) begin
        busy <= 1'b0;
        idx  <= '0;
      end else begin
        idx <= idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_x    <= cmd_x;
      cur_y    <= cmd_y;
      cur_cx   <= cmd_cx;
      cur_cy   <= cmd_cy;
      cur_ctrl <= cmd_ctrl;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (cur_ctrl.idle) begin
        out_px          <= '0;
        out_py          <= '0;
        out_pixel_valid <= 1'b0;
        out_last        <= 1'b1;
        out_done        <= 1'b1;
      end else begin
        out_px          <= px_w[PIX_BITS-1:0];
        out_py          <= py_w[PIX_BITS-1:0];
        out_pixel_valid <= 1'b1;
        out_last        <= (idx == LAST_POINT);
        out_done        <= cur_ctrl.done;
      end
    end
  end

  a_idle_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_pixel_valid |-> out_last && out_done)
    else $error("answer without a pixel is not a single final transfer");

  a_idle_index: assert property (@(posedge clk) disable iff (rst)
    busy && cur_ctrl.idle |-> (idx == '0))
    else $error("idle answer advanced the point counter");

  a_last_point: assert property (@(posedge clk) disable iff (rst)
    emit && !cur_ctrl.idle && (idx == LAST_POINT) |=> out_valid && out_last)
    else $error("eighth point not marked as last");

  a_mid_point: assert property (@(posedge clk) disable iff (rst)
    emit && !cur_ctrl.idle && (idx != LAST_POINT) |=> out_valid && !out_last)
    else $error("point before the eighth marked as last");

endmodule

// ===== design/circle_rasterizer.sv =====
// Midpoint circle rasteriser: walk front end, command queue and pixel emitter.
// A start or step transfer is written into the queue; its first pixel then passes
// through the emitter's command register and leaves from the output register.
// The emitter gives one pixel a cycle while the receiver is ready and loads the next
// command as it emits the last pixel; input is taken whenever the queue has room.
// Reset (rst, synchronous) empties the queue and output and leaves the walk idle.
module circle_rasterizer import crast_pkg::*; #(
  parameter int COORD_BITS  = COORD_BITS_DEF,
  parameter int RADIUS_BITS = RADIUS_BITS_DEF,
  parameter int SDATA_W     = ((2 * COORD_BITS + RADIUS_BITS + 7) / 8) * 8,
  parameter int MDATA_W     = ((2 * (COORD_BITS + 1) + 7) / 8) * 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  // s_tdata fields from bit 0: center_x, center_y, radius, zero padding
  input  logic [SDATA_W-1:0] s_tdata,
  // s_tuser fields from bit 0: action
  input  logic               s_tuser,
  output logic               m_tvalid,
  input  logic               m_tready,
  // m_tdata fields from bit 0: pixel_x, pixel_y, zero padding
  output logic [MDATA_W-1:0] m_tdata,
  // m_tuser fields from bit 0: pixel_valid, circle_done
  output logic [1:0]         m_tuser,
  // m_tlast: last_of_run
  output logic               m_tlast
);

  localparam int PIX_BITS = COORD_BITS + 1;
  localparam int SW       = RADIUS_BITS + 2;
  localparam int CMD_W    = 2 * SW + 2 * COORD_BITS + $bits(ctrl_t);

  logic                         f_push;
  logic                         q_ready;
  logic signed [SW-1:0]         f_x;
  logic signed [SW-1:0]         f_y;
  logic signed [COORD_BITS-1:0] f_cx;
  logic signed [COORD_BITS-1:0] f_cy;
  ctrl_t                        f_ctrl;

  logic                         q_valid;
  logic                         q_pop;
  logic [CMD_W-1:0]             q_wdata;
  logic [CMD_W-1:0]             q_rdata;
  logic signed [SW-1:0]         b_x;
  logic signed [SW-1:0]         b_y;
  logic signed [COORD_BITS-1:0] b_cx;
  logic signed [COORD_BITS-1:0] b_cy;
  ctrl_t                        b_ctrl;

  logic [PIX_BITS-1:0]          px;
  logic [PIX_BITS-1:0]          py;
  logic                         pix_valid;
  logic                         done;

  // Front end: walk state and command generation.
  crast_front #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS),
    .SW          (SW)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_action (s_tuser),
    .in_cx     (s_tdata[COORD_BITS-1:0]),
    .in_cy     (s_tdata[2*COORD_BITS-1:COORD_BITS]),
    .in_radius (s_tdata[2*COORD_BITS+RADIUS_BITS-1:2*COORD_BITS]),
    .cmd_push  (f_push),
    .cmd_ready (q_ready),
    .cmd_x     (f_x),
    .cmd_y     (f_y),
    .cmd_cx    (f_cx),
    .cmd_cy    (f_cy),
    .cmd_ctrl  (f_ctrl)
  );

  // Command queue.
  assign q_wdata = {f_ctrl, f_cy, f_cx, f_y, f_x};
  assign {b_ctrl, b_cy, b_cx, b_y, b_x} = q_rdata;

  crast_fifo #(
    .WIDTH (CMD_W)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (f_push),
    .ready (q_ready),
    .wdata (q_wdata),
    .valid (q_valid),
    .pop   (q_pop),
    .rdata (q_rdata)
  );

  // Pixel emitter.
  crast_back #(
    .COORD_BITS (COORD_BITS),
    .SW         (SW),
    .PIX_BITS   (PIX_BITS)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .cmd_valid       (q_valid),
    .cmd_pop         (q_pop),
    .cmd_x           (b_x),
    .cmd_y           (b_y),
    .cmd_cx          (b_cx),
    .cmd_cy          (b_cy),
    .cmd_ctrl        (b_ctrl),
    .out_valid       (m_tvalid),
    .out_ready       (m_tready),
    .out_px          (px),
    .out_py          (py),
    .out_pixel_valid (pix_valid),
    .out_last        (m_tlast),
    .out_done        (done)
  );

  // Output packing.
  assign m_tdata = MDATA_W'({py, px});
  assign m_tuser = {done, pix_valid};

endmodule

// ===== verif/tb_circle_rasterizer.sv =====
// Self-checking testbench of the midpoint circle rasteriser with a pixel scoreboard.
module tb_circle_rasterizer;
  import crast_pkg::*;

  localparam int CW          = COORD_BITS_DEF;
  localparam int RW          = RADIUS_BITS_DEF;
  localparam int PW          = CW + 1;
  localparam int DW          = RW + 4;
  localparam int SDATA_W     = ((2 * CW + RW + 7) / 8) * 8;
  localparam int MDATA_W     = ((2 * PW + 7) / 8) * 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 88;
  localparam int DRAIN_CYCLES = 20;

  // One pixel result as it leaves the block.
  typedef struct packed {
    logic [PW-1:0] px;
    logic [PW-1:0] py;
    logic          valid;
    logic          last;
    logic          done;
  } pixel_t;

  // Keeps its own copy of the octant walk and the queue of pixels still owed.
  class pixel_scoreboard;
    logic [RW-1:0]        walk_x;
    logic [RW-1:0]        walk_y;
    logic signed [DW-1:0] decision;
    logic signed [CW-1:0] centre_x;
    logic signed [CW-1:0] centre_y;
    bit                   walking;
    pixel_t               owed_pixels[$];
    int                   mismatches;

    function new();
      walk_x     = '0;
      walk_y     = '0;
      decision   = '0;
      centre_x   = '0;
      centre_y   = '0;
      walking    = 0;
      mismatches = 0;
    endfunction

    // Queue the eight symmetric points of (x, y), offset by the centre.
    function void push_octants(int x, int y, bit fin);
      pixel_t p;
      int     a;
      int     b;
      for (int k = 0; k < 8; k++) begin
        case (k)
          0: begin a = x;  b = y;  end
          1: begin a = -x; b = -y; end
          2: begin a = y;  b = x;  end
          3: begin a = -y; b = -x; end
          4: begin a = -y; b = x;  end
          5: begin a = y;  b = -x; end
          6: begin a = -x; b = y;  end
          default: begin a = x; b = -y; end
        endcase
        p.px    = PW'(a + int'(centre_x));
        p.py    = PW'(b + int'(centre_y));
        p.valid = 1'b1;
        p.last  = (k == 7);
        p.done  = fin;
        owed_pixels.push_back(p);
      end
    endfunction

    // Advance the model by one accepted input transfer.
    function void note_input(logic act, logic [CW-1:0] cx, logic [CW-1:0] cy,
                             logic [RW-1:0] r);
      int     x;
      int     y;
      int     d;
      bit     fin;
      pixel_t p;
      if (act == ACT_START) begin
        centre_x = cx;
        centre_y = cy;
        walk_x   = '0;
        walk_y   = r;
        decision = DW'(3 - 2 * int'(r));
        walking  = 1;
        push_octants(0, int'(r), 1'b0);
      end else if (!walking || walk_x > walk_y) begin
        // A step with no walk in progress gets a single empty answer.
        walking = 0;
        p       = '{px: '0, py: '0, valid: 1'b0, last: 1'b1, done: 1'b1};
        owed_pixels.push_back(p);
      end else begin
        x = int'(walk_x);
        y = int'(walk_y);
        d = int'(decision);
        if (d <= 0) begin
          d = d + 4 * x + 6;
          x = x + 1;
        end else begin
          d = d + 4 * (x - y) + 10;
          x = x + 1;
          y = y - 1;
        end
        decision = DW'(d);
        walk_x   = RW'(x);
        walk_y   = RW'(y);
        fin      = (x > y);
        if (fin) walking = 0;
        push_octants(x, y, fin);
      end
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    // Compare one accepted output transfer with the oldest owed pixel.
    function void check_result(pixel_t got);
      pixel_t want;
      if (owed_pixels.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h", $time, got);
        mismatches++;
      end else begin
        want = owed_pixels.pop_front();
        compare_field("pixel_x", want.px, got.px);
        compare_field("pixel_y", want.py, got.py);
        compare_field("pixel_valid", want.valid, got.valid);
        compare_field("last_of_run", want.last, got.last);
        compare_field("circle_done", want.done, got.done);
      end
    endfunction
  endclass

  typedef enum logic [1:0] {RX_FREE, RX_RANDOM, RX_TOGGLE, RX_SPARSE} rx_mode_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  // s_tdata fields from bit 0: center_x, center_y, radius, zero padding
  logic [SDATA_W-1:0] s_tdata = '0;
  // s_tuser fields from bit 0: action
  logic               s_tuser = 1'b0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  // m_tdata fields from bit 0: pixel_x, pixel_y, zero padding
  logic [MDATA_W-1:0] m_tdata;
  // m_tuser fields from bit 0: pixel_valid, circle_done
  logic [1:0]         m_tuser;
  logic               m_tlast;

  pixel_scoreboard    sb = new();
  pixel_t             seen;
  int                 cycle_count = 0;
  int                 burst_left = 0;
  int                 rx_phase_left = 0;
  rx_mode_t           rx_mode = RX_FREE;

  circle_rasterizer uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // Clock with a period of ten time units.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("circle_rasterizer: mismatch");
      $finish;
    end
  end

  // The receiver changes between free running, random, toggling and sparse windows.
  always @(posedge clk) begin
    if (rx_phase_left == 0) begin
      rx_mode       <= rx_mode_t'($urandom_range(0, 3));
      rx_phase_left <= $urandom_range(8, 48);
    end else begin
      rx_phase_left <= rx_phase_left - 1;
    end
    case (rx_mode)
      RX_FREE:   m_tready <= 1'b1;
      RX_RANDOM: m_tready <= ($urandom_range(0, 3) != 0);
      RX_TOGGLE: m_tready <= ~m_tready;
      default:   m_tready <= (rx_phase_left[2:0] == 3'd0);
    endcase
  end

  // Every accepted transfer on either side goes to the scoreboard.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready)
        sb.note_input(s_tuser, s_tdata[CW-1:0], s_tdata[2*CW-1:CW],
                      s_tdata[2*CW+RW-1:2*CW]);
      if (m_tvalid && m_tready) begin
        seen.px    = m_tdata[PW-1:0];
        seen.py    = m_tdata[2*PW-1:PW];
        seen.valid = m_tuser[0];
        seen.last  = m_tlast;
        seen.done  = m_tuser[1];
        sb.check_result(seen);
      end
    end
  end

  // Offer one item and hold it until its transfer; bursts are broken by random gaps.
  task automatic send_item(input logic act, input logic [CW-1:0] cx,
                           input logic [CW-1:0] cy, input logic [RW-1:0] r);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 10);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= SDATA_W'({r, cy, cx});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // A step carries random content in the fields that it ignores.
  task automatic send_step();
    send_item(ACT_STEP, CW'($urandom), CW'($urandom), RW'($urandom));
  endtask

  task automatic send_start(input logic [CW-1:0] cx, input logic [CW-1:0] cy,
                            input logic [RW-1:0] r);
    send_item(ACT_START, cx, cy, r);
  endtask

  initial begin
    int sent;
    int pick;
    int steps;
    logic [RW-1:0] r;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: a step before any circle, then a zero radius walk.
    send_step();
    send_start('0, '0, '0);
    repeat (2) send_step();

    // Extreme centre and radius, so that the pixel coordinates run beyond the centre range.
    send_start(12'h800, 12'h7FF, 10'h3FF);
    repeat (3) send_step();

    // A start in the middle of a walk restarts it; radius one ends after one step.
    send_start(12'h7FF, 12'h800, 10'd1);
    repeat (3) send_step();

    send_start(12'h555, 12'hAAA, 10'h2AA);
    repeat (3) send_step();

    // Radius three runs through both decision branches to the end and past it.
    send_start('0, '0, 10'd3);
    repeat (4) send_step();

    // Random part: mostly complete walks of small circles, some cut short.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        send_step();
        sent++;
      end else begin
        r = (pick == 1) ? RW'($urandom_range(0, 1023)) : RW'($urandom_range(0, 16));
        send_start(CW'($urandom), CW'($urandom), r);
        sent++;
        steps = (pick == 1) ? $urandom_range(1, 6) : (int'(r) * 3) / 4 + 2;
        if ($urandom_range(0, 4) == 0) steps = $urandom_range(0, steps);
        repeat (steps) begin
          send_step();
          sent++;
        end
      end
    end
    s_tvalid <= 1'b0;

    // Wait for every owed pixel, then wait on for anything stray.
    while (sb.owed_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatches == 0 && sb.owed_pixels.size() == 0)
      $display("circle_rasterizer: match");
    else
      $display("circle_rasterizer: mismatch");
    $finish;
  end

endmodule
